// ===== rtl/msk_pkg.sv =====
// Shared widths, defaults and types for the minimum-spread block.
`default_nettype none
package msk_pkg;

  localparam int VALUE_W       = 31;
  localparam int WIN_W         = 11;
  localparam int MAX_ITEMS_DEF = 1024;

  localparam logic [WIN_W-1:0]   WIN_RESET = WIN_W'(2);
  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  typedef struct packed {
    logic [VALUE_W-1:0] diff;
    logic               lt;
  } alu_res_t;

endpackage
`default_nettype wire

// ===== rtl/min_spread_of_k_values.sv =====
// Top level: loads a value set, sorts it in place and scans for the minimum window spread.
//
// Input channel (value_i, last_i) is taken on clk_i when in_valid_i is high and in_stall_o
// low. Values load at one per cycle into the store; values beyond MAX_ITEMS are dropped
// and flag overflow. The item with last_i set closes the set and the block stalls input
// until the result has entered the output register.
// After the last item the sequencer runs an insertion sort over the store with the single
// shared subtract/compare unit and the one read port: each value is read in ST_WV and
// compared in ST_CMP, one element shifted up per ST_CMP pass, with ST_PUT writing slot 0.
// The scan then visits ST_HI, ST_LO, ST_SUB and ST_MIN for each window position. A trivial
// window (k <= 1 or k > n) skips sort and scan and ends with a spread of zero.
// The result (min_spread_o, overflow_o) sits in an output register under out_valid_o and
// holds while out_stall_i is high; the next set loads while it waits.
// cfg_window_size_i is written when cfg_valid_i is high (cfg_ready_o is always high) and
// must only be written while the block is idle.
// Reset clears the sequencer, counts and output valid; window_size returns to 2.
// The store needs no clearing: only entries below the count are read.
`default_nettype none
module min_spread_of_k_values #(
  parameter int MAX_ITEMS = msk_pkg::MAX_ITEMS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [msk_pkg::VALUE_W-1:0] value_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [msk_pkg::VALUE_W-1:0] min_spread_o,
  output logic                        overflow_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [msk_pkg::WIN_W-1:0]   cfg_window_size_i
);
  import msk_pkg::*;

  localparam int AW   = $clog2(MAX_ITEMS);
  localparam int CW   = $clog2(MAX_ITEMS + 1);
  localparam int CMPW = (CW > WIN_W) ? CW : WIN_W;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ITEMS);

  localparam logic [3:0] ST_LOAD = 4'd0;
  localparam logic [3:0] ST_CHK  = 4'd1;
  localparam logic [3:0] ST_WV   = 4'd2;
  localparam logic [3:0] ST_CMP  = 4'd3;
  localparam logic [3:0] ST_PUT  = 4'd4;
  localparam logic [3:0] ST_HI   = 4'd5;
  localparam logic [3:0] ST_LO   = 4'd6;
  localparam logic [3:0] ST_SUB  = 4'd7;
  localparam logic [3:0] ST_MIN  = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [3:0]         state_q, state_d;
  logic [WIN_W-1:0]   k_q, k_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               ovf_seen_q, ovf_seen_d;
  logic [CW-1:0]      n_q, n_d;
  logic               ovf_q, ovf_d;
  logic [CW-1:0]      i_q, i_d;
  logic [CW-1:0]      j_q, j_d;
  logic [CW-1:0]      lo_q, lo_d;
  logic [CW-1:0]      hi_q, hi_d;
  logic [VALUE_W-1:0] v_q, v_d;
  logic [VALUE_W-1:0] hv_q, hv_d;
  logic [VALUE_W-1:0] d_q, d_d;
  logic [VALUE_W-1:0] best_q, best_d;
  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] spread_q, spread_d;
  logic               out_ovf_q, out_ovf_d;

  logic               in_acc;
  logic               out_free;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;
  logic [VALUE_W-1:0] alu_a;
  logic [VALUE_W-1:0] alu_b;
  alu_res_t           alu_res;
  logic [CMPW-1:0]    k_ext;
  logic [CMPW-1:0]    n_ext;
  logic [CW-1:0]      i_inc;
  logic [CW-1:0]      j_dec;

  assign in_stall_o   = (state_q != ST_LOAD);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign min_spread_o = spread_q;
  assign overflow_o   = out_ovf_q;

  assign k_ext = CMPW'(k_q);
  assign n_ext = CMPW'(n_q);
  assign i_inc = i_q + CW'(1);
  assign j_dec = j_q - CW'(1);

  msk_store #(
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  msk_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    ovf_seen_d  = ovf_seen_q;
    n_d         = n_q;
    ovf_d       = ovf_q;
    i_d         = i_q;
    j_d         = j_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    v_d         = v_q;
    hv_d        = hv_q;
    d_d         = d_q;
    best_d      = best_q;
    out_valid_d = out_valid_q;
    spread_d    = spread_q;
    out_ovf_d   = out_ovf_q;
    mem_we      = 1'b0;
    mem_waddr   = cnt_q[AW-1:0];
    mem_wdata   = value_i;
    mem_raddr   = i_q[AW-1:0];
    alu_a       = v_q;
    alu_b       = mem_rdata;

    if (cfg_valid_i) begin
      k_d = cfg_window_size_i;
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          mem_we    = (cnt_q < CNT_MAX);
          mem_waddr = cnt_q[AW-1:0];
          mem_wdata = value_i;
          if (cnt_q < CNT_MAX) begin
            cnt_d = cnt_q + CW'(1);
          end else begin
            ovf_seen_d = 1'b1;
          end
          if (last_i) begin
            n_d        = (cnt_q < CNT_MAX) ? cnt_q + CW'(1) : cnt_q;
            ovf_d      = ovf_seen_q || (cnt_q == CNT_MAX);
            cnt_d      = '0;
            ovf_seen_d = 1'b0;
            state_d    = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        if ((k_ext <= CMPW'(1)) || (k_ext > n_ext)) begin
          best_d  = '0;
          state_d = ST_DONE;
        end else begin
          best_d    = VALUE_MAX;
          i_d       = CW'(1);
          mem_raddr = AW'(1);
          state_d   = ST_WV;
        end
      end
      ST_WV: begin
        v_d       = mem_rdata;
        j_d       = i_q;
        mem_raddr = AW'(i_q - CW'(1));
        state_d   = ST_CMP;
      end
      ST_CMP: begin
        alu_a     = v_q;
        alu_b     = mem_rdata;
        mem_we    = 1'b1;
        mem_waddr = j_q[AW-1:0];
        if (alu_res.lt) begin
          mem_wdata = mem_rdata;
          j_d       = j_dec;
          if (j_dec != '0) begin
            mem_raddr = AW'(j_q - CW'(2));
          end else begin
            state_d = ST_PUT;
          end
        end else begin
          mem_wdata = v_q;
          i_d       = i_inc;
          mem_raddr = i_inc[AW-1:0];
          if (i_inc == n_q) begin
            lo_d    = '0;
            hi_d    = CW'(k_ext - CMPW'(1));
            state_d = ST_HI;
          end else begin
            state_d = ST_WV;
          end
        end
      end
      ST_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = v_q;
        i_d       = i_inc;
        mem_raddr = i_inc[AW-1:0];
        if (i_inc == n_q) begin
          lo_d    = '0;
          hi_d    = CW'(k_ext - CMPW'(1));
          state_d = ST_HI;
        end else begin
          state_d = ST_WV;
        end
      end
      ST_HI: begin
        mem_raddr = hi_q[AW-1:0];
        state_d   = ST_LO;
      end
      ST_LO: begin
        hv_d      = mem_rdata;
        mem_raddr = lo_q[AW-1:0];
        state_d   = ST_SUB;
      end
      ST_SUB: begin
        alu_a   = hv_q;
        alu_b   = mem_rdata;
        d_d     = alu_res.diff;
        state_d = ST_MIN;
      end
      ST_MIN: begin
        alu_a = d_q;
        alu_b = best_q;
        if (alu_res.lt) begin
          best_d = d_q;
        end
        if (hi_q == n_q - CW'(1)) begin
          state_d = ST_DONE;
        end else begin
          hi_d    = hi_q + CW'(1);
          lo_d    = lo_q + CW'(1);
          state_d = ST_HI;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          spread_d    = best_q;
          out_ovf_d   = ovf_q;
          state_d     = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      k_q         <= WIN_RESET;
      cnt_q       <= '0;
      ovf_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      cnt_q       <= cnt_d;
      ovf_seen_q  <= ovf_seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    ovf_q    <= ovf_d;
    i_q      <= i_d;
    j_q      <= j_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    v_q      <= v_d;
    hv_q     <= hv_d;
    d_q      <= d_d;
    best_q   <= best_d;
    spread_q <= spread_d;
    out_ovf_q <= out_ovf_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("store count beyond capacity");

  a_sort_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> (j_q != '0) && (j_q < n_q))
    else $error("sort shift address out of range");

  a_scan_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HI) |-> (hi_q < n_q) && (lo_q <= hi_q))
    else $error("scan window outside stored values");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && out_free |=> out_valid_o && (state_q == ST_LOAD))
    else $error("finished result not presented");

endmodule
`default_nettype wire

// ===== rtl/msk_alu.sv =====
// Shared subtract and compare unit used by the sort and scan sequencer.
`default_nettype none
module msk_alu (
  input  logic [msk_pkg::VALUE_W-1:0] a_i,
  input  logic [msk_pkg::VALUE_W-1:0] b_i,
  output msk_pkg::alu_res_t           res_o
);
  import msk_pkg::*;

  logic [VALUE_W:0] sub;

  assign sub        = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.diff = sub[VALUE_W-1:0];
  assign res_o.lt   = sub[VALUE_W];

endmodule
`default_nettype wire

// ===== rtl/msk_store.sv =====
// Value store: one write port and one registered read port.
`default_nettype none
module msk_store #(
  parameter int DEPTH = msk_pkg::MAX_ITEMS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [msk_pkg::VALUE_W-1:0] wdata_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [msk_pkg::VALUE_W-1:0] rdata_o
);
  import msk_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire
